[rtl/pfm_pkg.sv]
// Shared widths, codes and reset values of the pulse flow meter.
`timescale 1ns / 1ps

package pfm_pkg;

   localparam int ACTION_W   = 2;
   localparam int ADC_W      = 10;
   localparam int TIME_W     = 32;
   localparam int FLOW_W     = 16;
   localparam int LITER_W    = 32;
   localparam int VPP_W      = 20;
   localparam int UPL_W      = 20;
   localparam int SUB_W      = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOL_PULSE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNITS_LTR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIM = 3'd4;

   localparam logic [ADC_W-1:0]  HIGH_THR_RST  = 10'd614;
   localparam logic [ADC_W-1:0]  LOW_THR_RST   = 10'd410;
   localparam logic [VPP_W-1:0]  VOL_PULSE_RST = 20'd1000;
   localparam logic [UPL_W-1:0]  UNITS_LTR_RST = 20'd1000;
   localparam logic [TIME_W-1:0] STALE_LIM_RST = 32'd120000;

   localparam logic [TIME_W-1:0] INTERVAL_RST = 32'h0000ffff;
   localparam logic [FLOW_W-1:0] FLOW_MAX     = 16'hffff;

endpackage

[rtl/pfm_req_if.sv]
// Request channel: action, converter reading and tick time.
`timescale 1ns / 1ps

interface pfm_req_if
   import pfm_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADC_W-1:0]    adc_value;
   logic [TIME_W-1:0]   now;

   modport source (output valid, output action, output adc_value, output now, input ready);
   modport sink   (input valid, input action, input adc_value, input now, output ready);
endinterface

[rtl/pfm_rsp_if.sv]
// Response channel: flow rate and liter total.
`timescale 1ns / 1ps

interface pfm_rsp_if
   import pfm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FLOW_W-1:0]  flow_rate;
   logic [LITER_W-1:0] liter_count;

   modport source (output valid, output flow_rate, output liter_count, input ready);
   modport sink   (input valid, input flow_rate, input liter_count, output ready);
endinterface

[rtl/pfm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pfm_div
   import pfm_pkg::*;
#(
   parameter int DEND_W = 34,
   parameter int DSOR_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DEND_W-1:0] dividend,
   input  logic [DSOR_W-1:0] divisor,
   output logic              done,
   output logic [DEND_W-1:0] quotient,
   output logic [DSOR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DEND_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DEND_W-1:0] q_ff;
   logic [DSOR_W-1:0] r_ff;
   logic [DSOR_W-1:0] d_ff;

   logic [DSOR_W:0]   trial;
   logic [DSOR_W:0]   diff;
   logic              ge;

   assign trial = {r_ff, q_ff[DEND_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[DEND_W-2:0], ge};
         r_ff <= ge ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

[rtl/pulse_flow_meter.sv]
// Top level of the pulse flow meter: comparator, ring, sequencer and output register.
//
// Usage:
//   req_ch carries one transaction per action: start (set level, store time),
//   sample (hysteresis comparator, pulse counting) or report. Only a report
//   produces a transaction on rsp_ch, holding flow_rate and liter_count.
//   csr_we / csr_index / csr_wdata write the thresholds, volume per pulse,
//   units per liter and stale limit; write only while the block is idle.
// Steps (D = RING_DEPTH, a power of two; W = 32 + log2(D)):
//   start and action 3 finish in the idle step; a sample without a level change
//   does too, one with a change waits on the W-bit serial divider splitting
//   liters. A report makes a ring sum over the D slots, one slot per
//   cycle, a shift for the mean, then one pass through the same serial divider
//   for the flow, skipped with a zero mean; then the stale check and the emit
//   step. req_ch.ready is low while an item is at work.
// Reset clears level, totals, edge time and write slot, and loads every ring
//   slot with 0xffff; the block is ready in the first cycle after reset.
// A stalled receiver: the result sits in the output register; further items
//   are still taken, and a second report waits in its last step for the slot.
`timescale 1ns / 1ps

module pulse_flow_meter
   import pfm_pkg::*;
#(
   parameter int RING_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   pfm_req_if.sink               req_ch,
   pfm_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int SUM_W  = TIME_W + $clog2(RING_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PULSE,
      ST_SUM,
      ST_MEAN,
      ST_DIV_FLOW,
      ST_STALE,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [ADC_W-1:0]   high_thr_ff;
   logic [ADC_W-1:0]   low_thr_ff;
   logic [VPP_W-1:0]   vpp_ff;
   logic [UPL_W-1:0]   upl_ff;
   logic [TIME_W-1:0]  stale_lim_ff;

   logic               level_ff;
   logic [SUB_W-1:0]   sub_liter_ff;
   logic [LITER_W-1:0] liter_total_ff;
   logic [TIME_W-1:0]  last_edge_ff;
   logic [TIME_W-1:0]  ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]  slot_ff;

   logic [SLOT_W-1:0]  idx_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [FLOW_W-1:0]  flow_ff;

   logic               rsp_valid_ff;
   logic [FLOW_W-1:0]  rsp_flow_ff;
   logic [LITER_W-1:0] rsp_liter_ff;

   logic               div_start_ff;
   logic [SUM_W-1:0]   div_dend_ff;
   logic [TIME_W-1:0]  div_dsor_ff;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;
   logic [TIME_W-1:0]  div_rem;

   logic               req_fire;
   logic               level_next;
   logic [SUB_W-1:0]   pulse_sum;
   logic [UPL_W-1:0]   upl_eff;
   logic [TIME_W-1:0]  interval;
   logic [TIME_W-1:0]  age;
   logic [SLOT_W-1:0]  slot_next;
   logic [TIME_W-1:0]  mean;
   logic               pulse_go;
   logic               flow_go;
   logic               emit_go;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign level_next = level_ff ? !(req_ch.adc_value < low_thr_ff)
                                : (req_ch.adc_value > high_thr_ff);
   assign pulse_sum  = sub_liter_ff + SUB_W'(vpp_ff);
   assign upl_eff    = (upl_ff == '0) ? UPL_W'(1) : upl_ff;
   assign interval   = req_ch.now - last_edge_ff;
   assign age        = now_ff - last_edge_ff;
   assign slot_next  = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign mean       = sum_ff[SUM_W-1:SLOT_W];

   assign pulse_go = req_fire && (req_ch.action == ACT_SAMPLE) && (level_next != level_ff);
   assign flow_go  = (state_ff == ST_MEAN) && (mean != '0);
   assign emit_go  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   pfm_div #(
      .DEND_W (SUM_W),
      .DSOR_W (TIME_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_dend_ff),
      .divisor   (div_dsor_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff  <= HIGH_THR_RST;
         low_thr_ff   <= LOW_THR_RST;
         vpp_ff       <= VOL_PULSE_RST;
         upl_ff       <= UNITS_LTR_RST;
         stale_lim_ff <= STALE_LIM_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIGH_THR:  high_thr_ff  <= csr_wdata[ADC_W-1:0];
            CSR_LOW_THR:   low_thr_ff   <= csr_wdata[ADC_W-1:0];
            CSR_VOL_PULSE: vpp_ff       <= csr_wdata[VPP_W-1:0];
            CSR_UNITS_LTR: upl_ff       <= csr_wdata[UPL_W-1:0];
            CSR_STALE_LIM: stale_lim_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         level_ff       <= 1'b0;
         sub_liter_ff   <= '0;
         liter_total_ff <= '0;
         last_edge_ff   <= '0;
         slot_ff        <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= INTERVAL_RST;
         end
         rsp_valid_ff   <= 1'b0;
         div_start_ff   <= 1'b0;
         idx_ff         <= '0;
      end else begin
         div_start_ff <= pulse_go || flow_go;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_ch.action)
                     ACT_START: begin
                        level_ff     <= req_ch.adc_value > high_thr_ff;
                        last_edge_ff <= req_ch.now;
                     end
                     ACT_SAMPLE: begin
                        level_ff <= level_next;
                        if (pulse_go) begin
                           ring_ff[slot_ff] <= interval;
                           slot_ff          <= slot_next;
                           last_edge_ff     <= req_ch.now;
                           div_dend_ff      <= SUM_W'(pulse_sum);
                           div_dsor_ff      <= TIME_W'(upl_eff);
                           state_ff         <= ST_PULSE;
                        end
                     end
                     ACT_REPORT: begin
                        now_ff   <= req_ch.now;
                        idx_ff   <= '0;
                        sum_ff   <= '0;
                        state_ff <= ST_SUM;
                     end
                     default: ;
                  endcase
               end
            end
            ST_PULSE: begin
               if (div_done) begin
                  liter_total_ff <= liter_total_ff + div_quo[LITER_W-1:0];
                  sub_liter_ff   <= div_rem[SUB_W-1:0];
                  state_ff       <= ST_IDLE;
               end
            end
            ST_SUM: begin
               sum_ff <= sum_ff + SUM_W'(ring_ff[idx_ff]);
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SLOT_W'(RING_DEPTH - 1)) begin
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               if (flow_go) begin
                  div_dend_ff <= SUM_W'(vpp_ff);
                  div_dsor_ff <= mean;
                  state_ff    <= ST_DIV_FLOW;
               end else begin
                  flow_ff  <= FLOW_MAX;
                  state_ff <= ST_STALE;
               end
            end
            ST_DIV_FLOW: begin
               if (div_done) begin
                  flow_ff  <= (|div_quo[SUM_W-1:FLOW_W]) ? FLOW_MAX : div_quo[FLOW_W-1:0];
                  state_ff <= ST_STALE;
               end
            end
            ST_STALE: begin
               if (age > stale_lim_ff) begin
                  ring_ff[slot_ff] <= age;
                  slot_ff          <= slot_next;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_flow_ff  <= flow_ff;
                  rsp_liter_ff <= liter_total_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.flow_rate   = rsp_flow_ff;
   assign rsp_ch.liter_count = rsp_liter_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("response raised outside the emit step");

   a_report_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.action == ACT_REPORT |=> !req_ch.ready)
      else $error("request taken while a report is at work");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_PULSE || state_ff == ST_DIV_FLOW))
      else $error("divider finished with no step waiting for it");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(RING_DEPTH - 1))
      else $error("ring write slot beyond depth");

   a_depth_pow2: assert property (@(posedge clock)
      RING_DEPTH == (1 << SLOT_W))
      else $error("ring depth is not a power of two");

endmodule
